// ===== design/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

  localparam int TRIG_W  = 10;
  localparam int TIME_W  = 16;
  localparam int GAP_W   = 8;
  localparam int DIST_W  = 11;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_TRIG_WIDTH = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_GAP_LIMIT  = 2'd2;

  localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST = 10'd20;
  localparam logic [TIME_W-1:0] TIMEOUT_RST    = 16'd19140;
  localparam logic [GAP_W-1:0]  GAP_LIMIT_RST  = 8'd30;

  // floor(p / 58) == (p * 72316) >> 22 for every 16-bit p
  localparam int          RECIP_W  = 17;
  localparam int          CM_SHIFT = 22;
  localparam logic [RECIP_W-1:0] CM_RECIP = 17'd72316;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_width_us;
    logic [TIME_W-1:0] timeout_us;
    logic [GAP_W-1:0]  low_gap_limit;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [TIME_W-1:0] pulse_us;
  } res_t;

endpackage

// ===== design/uer_cfg_regs.sv =====
// APB-style register file holding the three ranger settings.
// Depends on uer_pkg.
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_width_us <= TRIG_WIDTH_RST;
      cfg_r.timeout_us       <= TIMEOUT_RST;
      cfg_r.low_gap_limit    <= GAP_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TRIG_WIDTH: cfg_r.trigger_width_us <= pwdata[TRIG_W-1:0];
        REG_TIMEOUT:    cfg_r.timeout_us       <= pwdata[TIME_W-1:0];
        REG_GAP_LIMIT:  cfg_r.low_gap_limit    <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRIG_WIDTH: prdata = {{(DATA_W-TRIG_W){1'b0}}, cfg_r.trigger_width_us};
      REG_TIMEOUT:    prdata = {{(DATA_W-TIME_W){1'b0}}, cfg_r.timeout_us};
      REG_GAP_LIMIT:  prdata = {{(DATA_W-GAP_W){1'b0}}, cfg_r.low_gap_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== design/uer_ctrl.sv =====
// Input register plus measurement sequencer: trigger, wait, echo timing.
// Depends on uer_pkg. Produces one registered result per accepted item.
module uer_ctrl
  import uer_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic start_req,
  input  logic echo,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_ECHO = 2'd3;

  logic a_valid_r, start_r, echo_r;
  logic b_valid_r;
  res_t res_r, res_nxt;
  logic b_ready, a_adv;

  logic [1:0]        phase_r, phase_nxt;
  logic [TRIG_W-1:0] trig_cnt_r, trig_cnt_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0] last_high_r, last_high_nxt;
  logic [GAP_W-1:0]  low_run_r, low_run_nxt;

  assign b_ready   = ~b_valid_r | res_ready;
  assign a_adv     = a_valid_r & b_ready;
  assign in_ready  = ~a_valid_r | b_ready;
  assign res_valid = b_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      start_r <= start_req;
      echo_r  <= echo;
    end
  end

  always_comb begin
    logic [TRIG_W-1:0] width;
    logic [GAP_W-1:0]  gap;
    logic              done;
    logic              tout;
    logic [TIME_W-1:0] pulse;
    width = (cfg.trigger_width_us == '0) ? TRIG_W'(1) : cfg.trigger_width_us;
    gap   = (cfg.low_gap_limit == '0) ? GAP_W'(1) : cfg.low_gap_limit;
    done  = 1'b0;
    tout  = 1'b0;
    pulse = '0;
    phase_nxt     = phase_r;
    trig_cnt_nxt  = trig_cnt_r;
    elapsed_nxt   = elapsed_r;
    last_high_nxt = last_high_r;
    low_run_nxt   = low_run_r;
    res_nxt.trigger = 1'b0;

    if (phase_r == PH_IDLE && start_r) begin
      phase_nxt    = PH_TRIG;
      trig_cnt_nxt = '0;
    end

    case (phase_nxt)
      PH_TRIG: begin
        res_nxt.trigger = 1'b1;
        trig_cnt_nxt = trig_cnt_nxt + TRIG_W'(1);
        if (trig_cnt_nxt >= width) phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_r) begin
          phase_nxt     = PH_ECHO;
          elapsed_nxt   = '0;
          last_high_nxt = '0;
          low_run_nxt   = '0;
          if (cfg.timeout_us == '0) begin
            done = 1'b1;
            tout = 1'b1;
          end
        end
      end
      PH_ECHO: begin
        if (elapsed_r != '1) elapsed_nxt = elapsed_r + TIME_W'(1);
        if (echo_r) begin
          last_high_nxt = elapsed_nxt;
          low_run_nxt   = '0;
          if (elapsed_nxt >= cfg.timeout_us) begin
            done  = 1'b1;
            tout  = 1'b1;
            pulse = elapsed_nxt;
          end
        end else begin
          low_run_nxt = low_run_r + GAP_W'(1);
          if (low_run_nxt >= gap) begin
            done  = 1'b1;
            pulse = last_high_r;
          end
        end
      end
      default: ;
    endcase

    if (done) phase_nxt = PH_IDLE;

    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done;
    res_nxt.timed_out = tout;
    res_nxt.pulse_us  = pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      trig_cnt_r  <= '0;
      elapsed_r   <= '0;
      last_high_r <= '0;
      low_run_r   <= '0;
      b_valid_r   <= 1'b0;
    end else begin
      if (a_adv) begin
        phase_r     <= phase_nxt;
        trig_cnt_r  <= trig_cnt_nxt;
        elapsed_r   <= elapsed_nxt;
        last_high_r <= last_high_nxt;
        low_run_r   <= low_run_nxt;
      end
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) res_r <= res_nxt;
  end

endmodule

// ===== design/uer_dist.sv =====
// Distance stage: pulse time / 58 by reciprocal multiply, into the output register.
// Depends on uer_pkg.
module uer_dist
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  res_t              res,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_res,
  output logic [DIST_W-1:0] out_dist
);

  localparam int PROD_W = TIME_W + RECIP_W;

  logic              out_valid_r;
  res_t              out_res_r;
  logic [DIST_W-1:0] dist_r;
  logic [PROD_W-1:0] prod;

  assign res_ready = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_dist  = dist_r;

  assign prod = PROD_W'(res.pulse_us) * PROD_W'(CM_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
      dist_r    <= prod[CM_SHIFT +: DIST_W];
    end
  end

endmodule

// ===== design/ultrasonic_echo_ranger_core.sv =====
// Ultrasonic echo ranger, top level: register port, sequencer and distance stage.
// Depends on uer_pkg, uer_cfg_regs, uer_ctrl and uer_dist.
//
// Usage: feed one item per microsecond tick on the in_ stream (start request and
// sampled echo level). Every accepted item yields exactly one result item on the
// out_ stream: trigger drive level, busy, done, timed-out flag, pulse time and
// distance in cm. Drive the sensor trigger pin from the trigger field.
// Pipeline: three register stages (input register, sequencer result register,
// distance output register) lie between an accepted item and its result.
// Throughput: one item per cycle while out_tready is high; the per-tick sequencer
// update and the 16x17 reciprocal multiply each fit in one register-to-register stage.
// Stalls: each of the three stages holds its item while the stage after it is
// full, so with out_tready low the block still takes up to three items before
// in_tready drops. No item is dropped or duplicated.
// Reset (rst_n low, synchronous): registers go to 20 / 19140 / 30, the sequencer
// to idle with cleared counters, and all pipeline stages empty.
// The user must write settings via cfg_ APB only while the block is idle (not enforced).
module ultrasonic_echo_ranger_core
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [0] start_req, [1] echo, [7:2] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
  // [19:4] pulse_us, [30:20] distance_cm, [31] zero
  output logic [31:0]       out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t              cfg;
  logic              mid_valid, mid_ready;
  res_t              mid_res;
  res_t              out_res;
  logic [DIST_W-1:0] out_dist;

  uer_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_req (in_tdata[0]),
    .echo      (in_tdata[1]),
    .res_valid (mid_valid),
    .res_ready (mid_ready),
    .res       (mid_res)
  );

  uer_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (mid_valid),
    .res_ready (mid_ready),
    .res       (mid_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_dist  (out_dist)
  );

  assign out_tdata = {1'b0, out_dist, out_res.pulse_us, out_res.timed_out,
                      out_res.done_res, out_res.busy_res, out_res.trigger};

endmodule

// ===== verif/tb_top.sv =====
// Testbench for ultrasonic_echo_ranger_core: streams echo ticks, predicts every result item.
// Depends on uer_pkg and the core; config goes in over the cfg_ APB port between phases.
module tb_top;
  import uer_pkg::*;

  localparam int          LIMIT      = 500000;
  localparam int          LONG_HOLD  = 400;
  localparam int          DRAIN_WAIT = 6;
  localparam int unsigned US_PER_CM  = 58;

  typedef enum logic [1:0] {RNG_IDLE, RNG_TRIG, RNG_WAIT, RNG_ECHO} rng_phase_t;

  // bit order matches out_tdata[30:0]
  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic [TIME_W-1:0] pulse_us;
    logic              timed_out;
    logic              done_res;
    logic              busy_res;
    logic              trigger;
  } ranger_res_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;  // [0] start_req, [1] echo, [7:2] zero
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [31:0]       out_tdata;         // [0] trigger, [1] busy, [2] done, [3] timed_out,
                                        // [19:4] pulse_us, [30:20] distance_cm
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  ultrasonic_echo_ranger_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // ranger shadow: settings and sequencer state
  cfg_t              ranger_cfg;
  rng_phase_t        ph        = RNG_IDLE;
  logic [TRIG_W-1:0] trig_cnt  = '0;
  logic [TIME_W-1:0] elapsed   = '0;
  logic [TIME_W-1:0] last_high = '0;
  logic [GAP_W-1:0]  low_run   = '0;

  logic [7:0]  tick_q[$];
  ranger_res_t pending_readings[$];
  ranger_res_t got_res, want_res;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  logic        long_hold_go   = 1'b0;
  logic        long_hold_done = 1'b0;
  logic        failed         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one microsecond tick through the sequencer; queues the reading it yields
  task automatic sense_tick(input logic start, input logic echo);
    ranger_res_t       r;
    logic [TRIG_W-1:0] width;
    logic [GAP_W-1:0]  gap;
    logic              fin;
    r     = '0;
    fin   = 1'b0;
    width = (ranger_cfg.trigger_width_us == '0) ? TRIG_W'(1) : ranger_cfg.trigger_width_us;
    gap   = (ranger_cfg.low_gap_limit == '0) ? GAP_W'(1) : ranger_cfg.low_gap_limit;
    if (ph == RNG_IDLE && start) begin
      ph       = RNG_TRIG;
      trig_cnt = '0;
    end
    case (ph)
      RNG_TRIG: begin
        r.trigger = 1'b1;
        trig_cnt  = trig_cnt + TRIG_W'(1);
        if (trig_cnt >= width) ph = RNG_WAIT;
      end
      RNG_WAIT: begin
        if (echo) begin
          ph        = RNG_ECHO;
          elapsed   = '0;
          last_high = '0;
          low_run   = '0;
          // rising edge sample is checked against the timeout too
          if (ranger_cfg.timeout_us == '0) begin
            fin         = 1'b1;
            r.timed_out = 1'b1;
          end
        end
      end
      RNG_ECHO: begin
        if (elapsed != '1) elapsed = elapsed + TIME_W'(1);
        if (echo) begin
          last_high = elapsed;
          low_run   = '0;
          if (elapsed >= ranger_cfg.timeout_us) begin
            fin         = 1'b1;
            r.timed_out = 1'b1;
            r.pulse_us  = elapsed;
          end
        end else begin
          low_run = low_run + GAP_W'(1);
          if (low_run >= gap) begin
            fin        = 1'b1;
            r.pulse_us = last_high;
          end
        end
      end
      default: ;
    endcase
    if (fin) ph = RNG_IDLE;
    r.done_res    = fin;
    r.busy_res    = (ph != RNG_IDLE);
    r.distance_cm = DIST_W'(r.pulse_us / US_PER_CM);
    pending_readings.push_back(r);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) sense_tick(in_tdata[0], in_tdata[1]);
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= tick_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (long_hold_go && !long_hold_done) begin
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_tready     <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $error("result item with none expected: %h", out_tdata);
        failed = 1'b1;
      end else begin
        want_res = pending_readings.pop_front();
        got_res  = out_tdata[30:0];
        check_field("trigger", want_res.trigger, got_res.trigger);
        check_field("busy_res", want_res.busy_res, got_res.busy_res);
        check_field("done_res", want_res.done_res, got_res.done_res);
        check_field("timed_out", want_res.timed_out, got_res.timed_out);
        check_field("pulse_us", want_res.pulse_us, got_res.pulse_us);
        check_field("distance_cm", want_res.distance_cm, got_res.distance_cm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_tick(input logic start, input logic echo);
    tick_q.push_back({6'b0, echo, start});
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_TRIG_WIDTH: ranger_cfg.trigger_width_us = val[TRIG_W-1:0];
      REG_TIMEOUT:    ranger_cfg.timeout_us       = val[TIME_W-1:0];
      REG_GAP_LIMIT:  ranger_cfg.low_gap_limit    = val[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input int tw, input int tmo, input int gap);
    cfg_write(REG_TRIG_WIDTH, DATA_W'(tw));
    cfg_write(REG_TIMEOUT, DATA_W'(tmo));
    cfg_write(REG_GAP_LIMIT, DATA_W'(gap));
  endtask

  // sampled at negedge so the sender's pops at posedge are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || pending_readings.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // drain, then feed closing ticks until the sequencer is back in idle
  task automatic settle_idle();
    wait_drained();
    while (ph != RNG_IDLE) begin
      push_tick(1'b0, ph == RNG_WAIT);
      wait_drained();
    end
  endtask

  // one well-formed measurement with random content: trigger, wait, gappy echo pulse
  task automatic queue_measurement(input int tw, input int tmo, input int gap);
    int w, g, hi_max, lo;
    w      = (tw == 0) ? 1 : tw;
    g      = (gap == 0) ? 1 : gap;
    hi_max = (tmo / 3 + 1 > 40) ? 40 : tmo / 3 + 1;
    push_tick(1'b1, 1'($urandom_range(1)));
    repeat (w - 1) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat ($urandom_range(0, 3)) push_tick($urandom_range(7) == 0, 1'b0);
    repeat ($urandom_range(1, 6)) begin
      repeat ($urandom_range(1, hi_max)) push_tick($urandom_range(7) == 0, 1'b1);
      if ($urandom_range(4) == 0 || g == 1) lo = g + $urandom_range(0, 2);
      else lo = $urandom_range(1, g - 1);
      repeat (lo) push_tick($urandom_range(7) == 0, 1'b0);
    end
    repeat (g) push_tick(1'b0, 1'b0);
  endtask

  task automatic run_random_phase(input int tw, input int tmo, input int gap, input int n);
    write_settings(tw, tmo, gap);
    while (tick_q.size() < n) begin
      repeat ($urandom_range(0, 3))
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      queue_measurement(tw, tmo, gap);
    end
    settle_idle();
  endtask

  initial begin
    ranger_cfg.trigger_width_us = TRIG_WIDTH_RST;
    ranger_cfg.timeout_us       = TIMEOUT_RST;
    ranger_cfg.low_gap_limit    = GAP_LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 63;

    // directed: echo ignored in idle and trigger, start ignored while busy and on done,
    // tolerated low gap, gap end, timeout end
    write_settings(2, 6, 2);
    push_tick(1'b0, 1'b1); push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1); push_tick(1'b1, 1'b0); push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1); push_tick(1'b0, 1'b0); push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0); push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1); push_tick(1'b0, 1'b1); push_tick(1'b0, 1'b1);
    repeat (6) push_tick(1'b0, 1'b1);
    settle_idle();
    // zero width and zero timeout: done as timed out on the rising edge
    write_settings(0, 0, 0);
    push_tick(1'b1, 1'b1); push_tick(1'b0, 1'b1);
    settle_idle();
    // zero gap limit: first low ends the pulse
    write_settings(0, 100, 0);
    push_tick(1'b1, 1'b0); push_tick(1'b0, 1'b1); push_tick(1'b0, 1'b0);
    settle_idle();

    run_random_phase(TRIG_WIDTH_RST, TIMEOUT_RST, GAP_LIMIT_RST, 200);
    repeat (2)
      run_random_phase($urandom_range(1, 4), $urandom_range(1, 150), $urandom_range(1, 6), 120);

    send_idle_pct = 63;
    recv_idle_pct = 34;
    repeat (3)
      run_random_phase($urandom_range(1, 4), $urandom_range(1, 150), $urandom_range(1, 6), 120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver stalls long enough that the core backs up into in_tready
    long_hold_go = 1'b1;
    run_random_phase($urandom_range(1, 4), $urandom_range(1, 150), $urandom_range(1, 6), 150);

    run_random_phase(1, 1, 1, 60);
    run_random_phase($urandom_range(1, 4), $urandom_range(1, 150), $urandom_range(1, 6), 80);

    wait_drained();
    if (pending_readings.size() != 0) begin
      $error("%0d expected result items never arrived", pending_readings.size());
      failed = 1'b1;
    end
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
